### design/fcoc_pkg.sv
`timescale 1ns / 1ps
// fcoc_pkg: shared types, codes and helpers for the framed command output controller.
// No dependencies; used by every other design file.
package fcoc_pkg;

  localparam int BYTE_W          = 8;
  localparam int COLOR_W         = 3;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Frame bytes
  localparam logic [BYTE_W-1:0] START_BYTE = 8'hFF;
  localparam logic [BYTE_W-1:0] REPLY_SOF  = 8'hFE;
  localparam logic [BYTE_W-1:0] REPLY_TAG  = 8'h01;
  localparam logic [BYTE_W-1:0] SUM_XOR    = 8'hFF;

  // Commands
  localparam logic [BYTE_W-1:0] CMD_RESTORE = 8'h02;
  localparam logic [BYTE_W-1:0] CMD_FLASH   = 8'h07;
  localparam logic [BYTE_W-1:0] CMD_COLOR   = 8'h0A;
  localparam logic [BYTE_W-1:0] CMD_FAN1    = 8'h20;
  localparam logic [BYTE_W-1:0] CMD_FAN2    = 8'h22;

  // Command arguments
  localparam logic [BYTE_W-1:0] ARG_ON        = 8'h01;
  localparam logic [BYTE_W-1:0] ARG_OFF       = 8'h02;
  localparam logic [BYTE_W-1:0] ARG_COLOR_MIN = 8'h01;
  localparam logic [BYTE_W-1:0] ARG_COLOR_MAX = 8'h08;

  // Reply status
  localparam logic [BYTE_W-1:0] ST_REJECT  = 8'h00;
  localparam logic [BYTE_W-1:0] ST_OK      = 8'h01;
  localparam logic [BYTE_W-1:0] ST_BAD_SUM = 8'h02;

  localparam logic [COLOR_W-1:0] COLOR_RED = 3'd1;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_CMD  = 3'd1,
    PH_LEN  = 3'd2,
    PH_DATA = 3'd3,
    PH_CHK  = 3'd4
  } phase_t;

  // Reply beat index
  localparam logic [2:0] BEAT_SOF    = 3'd0;
  localparam logic [2:0] BEAT_CMD    = 3'd1;
  localparam logic [2:0] BEAT_TAG    = 3'd2;
  localparam logic [2:0] BEAT_STATUS = 3'd3;
  localparam logic [2:0] BEAT_LAST   = 3'd4;

  // One finished command, handed from parser to reply sender
  typedef struct packed {
    logic [BYTE_W-1:0]  cmd;
    logic [BYTE_W-1:0]  status;
    logic               flash;
    logic [COLOR_W-1:0] color;
    logic               fan1;
    logic               fan2;
  } rec_t;

  // Status color code to lit LEDs {red, green, blue}
  function automatic logic [2:0] lit_of(input logic [COLOR_W-1:0] color);
    logic [2:0] lit;
    unique case (color)
      3'd0: lit = 3'b000;
      3'd1: lit = 3'b100;
      3'd2: lit = 3'b010;
      3'd3: lit = 3'b001;
      3'd4: lit = 3'b110;
      3'd5: lit = 3'b111;
      3'd6: lit = 3'b101;
      3'd7: lit = 3'b011;
      default: lit = 3'b000;
    endcase
    return lit;
  endfunction

endpackage

### design/fcoc_rx_if.sv
`timescale 1ns / 1ps
// fcoc_rx_if: valid/ready channel carrying host bytes into the controller.
// Uses fcoc_pkg for the byte width.
interface fcoc_rx_if;
  logic                        valid;
  logic                        ready;
  logic [fcoc_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

### design/fcoc_reply_if.sv
`timescale 1ns / 1ps
// fcoc_reply_if: valid/ready channel carrying reply bytes and output state.
// Uses fcoc_pkg for widths.
interface fcoc_reply_if;
  logic                         valid;
  logic                         ready;
  logic [fcoc_pkg::BYTE_W-1:0]  reply_byte;
  logic                         reply_last;
  logic                         flash_on;
  logic [fcoc_pkg::COLOR_W-1:0] led_color;
  logic [2:0]                   rgb_lit;
  logic                         fan1_on;
  logic                         fan2_on;

  modport source (output valid, output reply_byte, output reply_last, output flash_on,
                  output led_color, output rgb_lit, output fan1_on, output fan2_on,
                  input ready);
  modport sink   (input valid, input reply_byte, input reply_last, input flash_on,
                  input led_color, input rgb_lit, input fan1_on, input fan2_on,
                  output ready);
endinterface

### design/fcoc_front.sv
`timescale 1ns / 1ps
// fcoc_front: frame parser, checksum check and command execution.
// Uses fcoc_pkg and fcoc_rx_if; pushes one rec_t per frame into the queue.
module fcoc_front (
  input  logic          clk,
  input  logic          rst,
  fcoc_rx_if.sink       rx,
  input  logic          q_full,
  output logic          push,
  output fcoc_pkg::rec_t push_rec
);

  fcoc_pkg::phase_t phase, phase_next;

  logic [fcoc_pkg::BYTE_W-1:0]  cmd, cmd_next;
  logic [fcoc_pkg::BYTE_W-1:0]  len, len_next;
  logic [fcoc_pkg::BYTE_W-1:0]  rem, rem_next;
  logic [fcoc_pkg::BYTE_W-1:0]  sum, sum_next;
  logic [fcoc_pkg::BYTE_W-1:0]  first, first_next;
  logic                         flash, flash_next;
  logic [fcoc_pkg::COLOR_W-1:0] color, color_next;
  logic                         fan1, fan1_next;
  logic                         fan2, fan2_next;
  logic [fcoc_pkg::BYTE_W-1:0]  status;
  logic                         take;
  logic [fcoc_pkg::BYTE_W-1:0]  b;

  // Only the checksum byte needs room in the queue
  assign rx.ready = (phase != fcoc_pkg::PH_CHK) || !q_full;
  assign take     = rx.valid && rx.ready;
  assign b        = rx.rx_byte;

  always_comb begin
    phase_next = phase;
    if (take) begin
      unique case (phase)
        fcoc_pkg::PH_IDLE: if (b == fcoc_pkg::START_BYTE) phase_next = fcoc_pkg::PH_CMD;
        fcoc_pkg::PH_CMD:  phase_next = fcoc_pkg::PH_LEN;
        fcoc_pkg::PH_LEN:  phase_next = (b != '0) ? fcoc_pkg::PH_DATA : fcoc_pkg::PH_CHK;
        fcoc_pkg::PH_DATA: if (rem == 8'd1) phase_next = fcoc_pkg::PH_CHK;
        fcoc_pkg::PH_CHK:  phase_next = fcoc_pkg::PH_IDLE;
        default:           phase_next = fcoc_pkg::PH_IDLE;
      endcase
    end
  end

  // Command execution against the output state (checksum byte only)
  always_comb begin
    flash_next = flash;
    color_next = color;
    fan1_next  = fan1;
    fan2_next  = fan2;
    status     = fcoc_pkg::ST_BAD_SUM;
    if ((sum ^ fcoc_pkg::SUM_XOR) == b) begin
      status = fcoc_pkg::ST_OK;
      unique case (cmd)
        fcoc_pkg::CMD_RESTORE: begin
          flash_next = 1'b0;
          color_next = fcoc_pkg::COLOR_RED;
          fan1_next  = 1'b0;
          fan2_next  = 1'b0;
        end
        fcoc_pkg::CMD_FLASH: begin
          if (first == fcoc_pkg::ARG_ON)       flash_next = 1'b1;
          else if (first == fcoc_pkg::ARG_OFF) flash_next = 1'b0;
          else                                 status     = fcoc_pkg::ST_REJECT;
        end
        fcoc_pkg::CMD_COLOR: begin
          if (first >= fcoc_pkg::ARG_COLOR_MIN && first <= fcoc_pkg::ARG_COLOR_MAX)
            color_next = fcoc_pkg::COLOR_W'(first - 8'd1);
        end
        fcoc_pkg::CMD_FAN1: begin
          if (first == fcoc_pkg::ARG_ON)       fan1_next = 1'b1;
          else if (first == fcoc_pkg::ARG_OFF) fan1_next = 1'b0;
        end
        fcoc_pkg::CMD_FAN2: begin
          if (first == fcoc_pkg::ARG_ON)       fan2_next = 1'b1;
          else if (first == fcoc_pkg::ARG_OFF) fan2_next = 1'b0;
        end
        default: status = fcoc_pkg::ST_REJECT;
      endcase
    end
  end

  always_comb begin
    cmd_next   = cmd;
    len_next   = len;
    rem_next   = rem;
    sum_next   = sum;
    first_next = first;
    push       = 1'b0;
    if (take) begin
      unique case (phase)
        fcoc_pkg::PH_CMD: begin
          cmd_next = b;
          sum_next = b;
        end
        fcoc_pkg::PH_LEN: begin
          len_next   = b;
          rem_next   = b;
          first_next = '0;
          sum_next   = sum + b;
        end
        fcoc_pkg::PH_DATA: begin
          if (rem == len) first_next = b;
          sum_next = sum + b;
          rem_next = rem - 8'd1;
        end
        fcoc_pkg::PH_CHK: push = 1'b1;
        default: ;
      endcase
    end
  end

  assign push_rec = '{cmd: cmd, status: status, flash: flash_next, color: color_next,
                      fan1: fan1_next, fan2: fan2_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= fcoc_pkg::PH_IDLE;
      cmd   <= '0;
      len   <= '0;
      rem   <= '0;
      sum   <= '0;
      first <= '0;
      flash <= 1'b0;
      color <= fcoc_pkg::COLOR_RED;
      fan1  <= 1'b0;
      fan2  <= 1'b0;
    end else begin
      phase <= phase_next;
      cmd   <= cmd_next;
      len   <= len_next;
      rem   <= rem_next;
      sum   <= sum_next;
      first <= first_next;
      if (push) begin
        flash <= flash_next;
        color <= color_next;
        fan1  <= fan1_next;
        fan2  <= fan2_next;
      end
    end
  end

  a_push_to_idle: assert property (@(posedge clk) disable iff (rst)
    push |=> phase == fcoc_pkg::PH_IDLE)
    else $error("parser not idle after frame end");

  a_data_count: assert property (@(posedge clk) disable iff (rst)
    phase == fcoc_pkg::PH_DATA |-> rem != '0)
    else $error("data phase with no bytes left");

  a_push_room: assert property (@(posedge clk) disable iff (rst) push |-> !q_full)
    else $error("frame end pushed into full queue");

endmodule

### design/fcoc_queue.sv
`timescale 1ns / 1ps
// fcoc_queue: small register FIFO of finished commands between parser and sender.
// Uses fcoc_pkg::rec_t.
module fcoc_queue #(
  parameter int DEPTH = fcoc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  fcoc_pkg::rec_t push_rec,
  input  logic           pop,
  output fcoc_pkg::rec_t head,
  output logic           full,
  output logic           empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);

  fcoc_pkg::rec_t   mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_MAX) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_MAX) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("pop from empty queue");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count out of range");

endmodule

### design/fcoc_back.sv
`timescale 1ns / 1ps
// fcoc_back: sends one 5-byte reply per queued command.
// Uses fcoc_pkg and fcoc_reply_if; pops records from fcoc_queue.
module fcoc_back (
  input  logic           clk,
  input  logic           rst,
  input  fcoc_pkg::rec_t head,
  input  logic           q_empty,
  output logic           pop,
  fcoc_reply_if.source   reply
);

  logic           busy;
  logic [2:0]     beat;
  fcoc_pkg::rec_t cur;
  logic           last;

  assign last = (beat == fcoc_pkg::BEAT_LAST);
  assign pop  = !q_empty && (!busy || (reply.ready && last));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      beat <= fcoc_pkg::BEAT_SOF;
    end else if (pop) begin
      busy <= 1'b1;
      beat <= fcoc_pkg::BEAT_SOF;
    end else if (busy && reply.ready) begin
      if (last) busy <= 1'b0;
      else      beat <= beat + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= head;
  end

  always_comb begin
    unique case (beat)
      fcoc_pkg::BEAT_SOF:    reply.reply_byte = fcoc_pkg::REPLY_SOF;
      fcoc_pkg::BEAT_CMD:    reply.reply_byte = cur.cmd;
      fcoc_pkg::BEAT_TAG:    reply.reply_byte = fcoc_pkg::REPLY_TAG;
      fcoc_pkg::BEAT_STATUS: reply.reply_byte = cur.status;
      fcoc_pkg::BEAT_LAST:
        reply.reply_byte = (cur.cmd + fcoc_pkg::REPLY_TAG + cur.status) ^ fcoc_pkg::SUM_XOR;
      default:               reply.reply_byte = '0;
    endcase
  end

  assign reply.valid      = busy;
  assign reply.reply_last = last;
  assign reply.flash_on   = cur.flash;
  assign reply.led_color  = cur.color;
  assign reply.rgb_lit    = fcoc_pkg::lit_of(cur.color);
  assign reply.fan1_on    = cur.fan1;
  assign reply.fan2_on    = cur.fan2;

  a_beat_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> beat <= fcoc_pkg::BEAT_LAST)
    else $error("reply beat out of range");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    reply.valid && reply.ready && reply.reply_last && q_empty |=> !busy)
    else $error("sender still busy after last beat with nothing queued");

  a_hold_stable: assert property (@(posedge clk) disable iff (rst)
    reply.valid && !reply.ready |=> reply.valid && $stable(reply.reply_byte))
    else $error("reply byte changed while waiting");

endmodule

### design/framed_command_output_controller.sv
`timescale 1ns / 1ps
// framed_command_output_controller: top level, parser -> command queue -> reply sender.
// Uses fcoc_pkg, fcoc_rx_if, fcoc_reply_if, fcoc_front, fcoc_queue, fcoc_back.

// Host bytes arrive on rx, one request per byte, and are taken at one byte per
// cycle unless rx stalls. A frame is 0xFF, command, length, length data bytes,
// checksum; bytes outside a frame other than 0xFF are dropped. The checksum
// byte runs the command (flash 0x07, color 0x0A, fans 0x20/0x22, restore 0x02)
// and queues a reply; the sender then emits five requests on reply: 0xFE,
// command, 0x01, status, checksum, with reply_last on the fifth and the updated
// output state on all five. The checksum byte's record is written into the
// command queue and then popped into the sender, which raises reply.valid. The
// reply port moves one byte per cycle while reply.ready is high; rx stalls only
// on a checksum byte while the QUEUE_DEPTH-entry command queue is full, so
// short frames back to back are paced by the reply port.
module framed_command_output_controller #(
  parameter int QUEUE_DEPTH = fcoc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  fcoc_rx_if.sink      rx,
  fcoc_reply_if.source reply
);

  // parser -> queue
  logic           push;
  fcoc_pkg::rec_t push_rec;
  logic           q_full;

  // queue -> sender
  logic           pop;
  fcoc_pkg::rec_t head;
  logic           q_empty;

  fcoc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .rx       (rx),
    .q_full   (q_full),
    .push     (push),
    .push_rec (push_rec)
  );

  fcoc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  fcoc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .q_empty (q_empty),
    .pop     (pop),
    .reply   (reply)
  );

endmodule

### tb/sv/framed_command_output_controller_tb.sv
`timescale 1ns / 1ps
// framed_command_output_controller_tb: self-checking bench for the frame parser and reply path.
// Needs fcoc_pkg, fcoc_rx_if, fcoc_reply_if and the framed_command_output_controller RTL.
module framed_command_output_controller_tb;

  localparam int    BYTE_W       = fcoc_pkg::BYTE_W;
  localparam int    COLOR_W      = fcoc_pkg::COLOR_W;
  localparam int    CLK_HALF_NS  = 4;
  localparam int    RESET_CYCLES = 8;
  localparam int    IDLE_PCT     = 9;     // chance that a side idles in a given cycle
  localparam int    HOLD_CYCLES  = 200;   // long reply hold-off used to fill the block
  localparam int    DRAIN_CYCLES = 20;    // settle time after the last expected reply byte
  localparam int    RANDOM_BYTES = 160;
  localparam int    LONG_LEN     = 64;
  localparam int    LIMIT_NS     = 2_000_000;

  // One expected reply request, all fields at the port widths
  typedef struct {
    logic [BYTE_W-1:0]  data;
    logic               last;
    logic               flash;
    logic [COLOR_W-1:0] color;
    logic [2:0]         lit;
    logic               fan1;
    logic               fan2;
  } reply_beat_t;

  logic clk;
  logic rst;

  fcoc_rx_if    rx_ch ();
  fcoc_reply_if reply_ch ();

  framed_command_output_controller u_top (
    .clk   (clk),
    .rst   (rst),
    .rx    (rx_ch),
    .reply (reply_ch)
  );

  // ---------------------------------------------------------------------------
  // Clock, hard stop
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #(CLK_HALF_NS) clk = ~clk;
  end

  // Generous cap, well above the slowest legal run.
  initial begin
    #(LIMIT_NS);
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Shared bench state
  // ---------------------------------------------------------------------------
  reply_beat_t expected_replies[$];   // reply bytes owed by the block, oldest first
  int          fail_count = 0;
  int          bytes_sent = 0;
  logic        quiet      = 1'b0;     // both sides stop idling while set
  int          hold_token = 0;        // bump to request one long reply hold-off
  int          hold_ack   = 0;
  int          hold_left  = 0;

  // Expected-side copy of the parser and the output state
  fcoc_pkg::phase_t   host_phase = fcoc_pkg::PH_IDLE;
  logic [BYTE_W-1:0]  host_cmd   = '0;
  logic [BYTE_W-1:0]  host_len   = '0;
  logic [BYTE_W-1:0]  host_left  = '0;
  logic [BYTE_W-1:0]  host_sum   = '0;
  logic [BYTE_W-1:0]  host_arg0  = '0;
  logic               flash_state = 1'b0;
  logic [COLOR_W-1:0] color_state = fcoc_pkg::COLOR_RED;
  logic               fan1_state  = 1'b0;
  logic               fan2_state  = 1'b0;

  // Color code to lit LEDs {red, green, blue}
  logic [2:0] leds_for_color [0:7] = '{3'b000, 3'b100, 3'b010, 3'b001,
                                       3'b110, 3'b111, 3'b101, 3'b011};

  // ---------------------------------------------------------------------------
  // Command execution: updates the output state, returns the reply status.
  // Only called once a frame's checksum has matched.
  // ---------------------------------------------------------------------------
  function automatic logic [BYTE_W-1:0] apply_command();
    logic [BYTE_W-1:0] st;
    st = fcoc_pkg::ST_OK;
    case (host_cmd)
      fcoc_pkg::CMD_RESTORE: begin
        flash_state = 1'b0;
        color_state = fcoc_pkg::COLOR_RED;
        fan1_state  = 1'b0;
        fan2_state  = 1'b0;
      end
      fcoc_pkg::CMD_FLASH: begin
        // only the flash refuses an argument it does not know
        if (host_arg0 == fcoc_pkg::ARG_ON) flash_state = 1'b1;
        else if (host_arg0 == fcoc_pkg::ARG_OFF) flash_state = 1'b0;
        else st = fcoc_pkg::ST_REJECT;
      end
      fcoc_pkg::CMD_COLOR: begin
        if (host_arg0 >= fcoc_pkg::ARG_COLOR_MIN && host_arg0 <= fcoc_pkg::ARG_COLOR_MAX)
          color_state = COLOR_W'(host_arg0 - fcoc_pkg::ARG_COLOR_MIN);
      end
      fcoc_pkg::CMD_FAN1: begin
        if (host_arg0 == fcoc_pkg::ARG_ON) fan1_state = 1'b1;
        else if (host_arg0 == fcoc_pkg::ARG_OFF) fan1_state = 1'b0;
      end
      fcoc_pkg::CMD_FAN2: begin
        if (host_arg0 == fcoc_pkg::ARG_ON) fan2_state = 1'b1;
        else if (host_arg0 == fcoc_pkg::ARG_OFF) fan2_state = 1'b0;
      end
      default: st = fcoc_pkg::ST_REJECT;
    endcase
    return st;
  endfunction

  // ---------------------------------------------------------------------------
  // Parser step for one accepted host byte. A checksum byte queues the five
  // reply bytes; every other byte only moves the frame state along.
  // ---------------------------------------------------------------------------
  function automatic void parse_host_byte(logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] status;
    logic [BYTE_W-1:0] reply_sum;
    logic [BYTE_W-1:0] frame [0:4];
    reply_beat_t       beat;
    case (host_phase)
      fcoc_pkg::PH_IDLE: begin
        // anything but the start byte is line noise
        if (b == fcoc_pkg::START_BYTE) host_phase = fcoc_pkg::PH_CMD;
      end
      fcoc_pkg::PH_CMD: begin
        host_cmd   = b;
        host_sum   = b;
        host_phase = fcoc_pkg::PH_LEN;
      end
      fcoc_pkg::PH_LEN: begin
        host_len   = b;
        host_left  = b;
        host_arg0  = '0;          // empty frame acts as argument zero
        host_sum   = host_sum + b;
        host_phase = (b != '0) ? fcoc_pkg::PH_DATA : fcoc_pkg::PH_CHK;
      end
      fcoc_pkg::PH_DATA: begin
        if (host_left == host_len) host_arg0 = b;
        host_sum  = host_sum + b;
        host_left = host_left - 1'b1;
        if (host_left == '0) host_phase = fcoc_pkg::PH_CHK;
      end
      fcoc_pkg::PH_CHK: begin
        host_phase = fcoc_pkg::PH_IDLE;
        if ((host_sum ^ fcoc_pkg::SUM_XOR) != b) status = fcoc_pkg::ST_BAD_SUM;
        else status = apply_command();
        reply_sum = host_cmd + fcoc_pkg::REPLY_TAG + status;
        reply_sum = reply_sum ^ fcoc_pkg::SUM_XOR;
        frame[fcoc_pkg::BEAT_SOF]    = fcoc_pkg::REPLY_SOF;
        frame[fcoc_pkg::BEAT_CMD]    = host_cmd;
        frame[fcoc_pkg::BEAT_TAG]    = fcoc_pkg::REPLY_TAG;
        frame[fcoc_pkg::BEAT_STATUS] = status;
        frame[fcoc_pkg::BEAT_LAST]   = reply_sum;
        for (int k = 0; k < 5; k++) begin
          beat.data  = frame[k];
          beat.last  = (k == int'(fcoc_pkg::BEAT_LAST));
          beat.flash = flash_state;
          beat.color = color_state;
          beat.lit   = leds_for_color[color_state];
          beat.fan1  = fan1_state;
          beat.fan2  = fan2_state;
          expected_replies.push_back(beat);
        end
      end
      default: host_phase = fcoc_pkg::PH_IDLE;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Host side: one request per byte. valid stays high from one byte to the
  // next unless a random gap is taken, so it is never lowered and raised in
  // the same step.
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    parse_host_byte(b);
    bytes_sent++;
  endtask

  // Whole frame: start, command, length, data (arg0 first, rest random), checksum.
  task automatic send_frame(input logic [BYTE_W-1:0] cmd, input logic [BYTE_W-1:0] len,
                            input logic [BYTE_W-1:0] arg0, input bit bad_sum);
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] d;
    sum = cmd + len;
    send_byte(fcoc_pkg::START_BYTE);
    send_byte(cmd);
    send_byte(len);
    for (int i = 0; i < int'(len); i++) begin
      d = (i == 0) ? arg0 : BYTE_W'($urandom);
      sum = sum + d;
      send_byte(d);
    end
    sum = sum ^ fcoc_pkg::SUM_XOR;
    if (bad_sum) sum = sum ^ BYTE_W'($urandom_range(1, 255));
    send_byte(sum);
  endtask

  // ---------------------------------------------------------------------------
  // Reply side: random ready with ~9% idling, none while quiet, and a counted
  // hold-off whenever a test bumps hold_token.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_token != hold_ack) begin
      hold_ack  = hold_token;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      reply_ch.ready <= 1'b0;
    end else begin
      reply_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic check_field(input string name, input logic [BYTE_W-1:0] expv,
                             input logic [BYTE_W-1:0] act);
    if (act !== expv) begin
      $error("%s mismatch: expected 0x%02h, got 0x%02h", name, expv, act);
      fail_count++;
    end
  endtask

  // Every accepted reply request is matched against the oldest expectation.
  always @(posedge clk) begin
    reply_beat_t want;
    if (!rst && reply_ch.valid && reply_ch.ready) begin
      if (expected_replies.size() == 0) begin
        $error("reply_byte 0x%02h with no reply pending", reply_ch.reply_byte);
        fail_count++;
      end else begin
        want = expected_replies.pop_front();
        check_field("reply_byte", want.data,  reply_ch.reply_byte);
        check_field("reply_last", want.last,  reply_ch.reply_last);
        check_field("flash_on",   want.flash, reply_ch.flash_on);
        check_field("led_color",  want.color, reply_ch.led_color);
        check_field("rgb_lit",    want.lit,   reply_ch.rgb_lit);
        check_field("fan1_on",    want.fan1,  reply_ch.fan1_on);
        check_field("fan2_on",    want.fan2,  reply_ch.fan2_on);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Bytes outside a frame that are not the start byte produce nothing.
  task automatic test_idle_bytes();
    send_byte(8'h00);
    send_byte(fcoc_pkg::REPLY_SOF);
    send_byte(8'h7F);
  endtask

  // Each command once with a good checksum; restore goes as an empty frame.
  task automatic test_commands();
    send_frame(fcoc_pkg::CMD_FLASH, 8'd1, fcoc_pkg::ARG_ON, 1'b0);
    send_frame(fcoc_pkg::CMD_COLOR, 8'd1, fcoc_pkg::ARG_COLOR_MAX, 1'b0);
    send_frame(fcoc_pkg::CMD_FAN1,  8'd1, fcoc_pkg::ARG_ON, 1'b0);
    send_frame(fcoc_pkg::CMD_FAN2,  8'd1, fcoc_pkg::ARG_ON, 1'b0);
    send_frame(fcoc_pkg::CMD_RESTORE, 8'd0, 8'h00, 1'b0);
  endtask

  // Start byte used as command and data inside a frame, with a wrong checksum.
  task automatic test_bad_checksum();
    send_frame(fcoc_pkg::START_BYTE, 8'd1, fcoc_pkg::START_BYTE, 1'b1);
  endtask

  // Empty flash frame: argument reads as zero, so the command is refused.
  task automatic test_empty_frame();
    send_frame(fcoc_pkg::CMD_FLASH, 8'd0, 8'h00, 1'b0);
  endtask

  // Long frame, still a well-formed color change.
  task automatic test_long_frame();
    send_frame(fcoc_pkg::CMD_COLOR, BYTE_W'(LONG_LEN), 8'd5, 1'b0);
  endtask

  // Reply side held off for a long stretch while short frames keep coming:
  // the command queue fills and rx has to stall on a checksum byte.
  task automatic test_backpressure();
    quiet      <= 1'b1;
    hold_token <= hold_token + 1;
    for (int i = 0; i < 8; i++)
      send_frame((i % 2 == 0) ? fcoc_pkg::CMD_FAN1 : fcoc_pkg::CMD_FAN2, 8'd0, 8'h00, 1'b0);
    quiet <= 1'b0;
  endtask

  // Mostly well-formed frames with random content, plus noise and bad sums.
  // The middle third runs with no idling on either side.
  task automatic test_random_traffic();
    int                start_count;
    logic [BYTE_W-1:0] cmd;
    logic [BYTE_W-1:0] len;
    logic [BYTE_W-1:0] arg0;
    start_count = bytes_sent;
    while (bytes_sent - start_count < RANDOM_BYTES) begin
      if (bytes_sent - start_count >= RANDOM_BYTES / 3 &&
          bytes_sent - start_count <  2 * RANDOM_BYTES / 3)
        quiet <= 1'b1;
      else
        quiet <= 1'b0;
      if ($urandom_range(99) < 8) begin
        // noise; may itself be a start byte and open a frame
        send_byte(BYTE_W'($urandom));
      end else begin
        case ($urandom_range(5))
          0: cmd = fcoc_pkg::CMD_RESTORE;
          1: cmd = fcoc_pkg::CMD_FLASH;
          2: cmd = fcoc_pkg::CMD_COLOR;
          3: cmd = fcoc_pkg::CMD_FAN1;
          4: cmd = fcoc_pkg::CMD_FAN2;
          default: cmd = BYTE_W'($urandom);
        endcase
        len = ($urandom_range(9) < 8) ? BYTE_W'($urandom_range(0, 3))
                                      : BYTE_W'($urandom_range(4, 12));
        case ($urandom_range(5))
          0: arg0 = 8'h00;
          1: arg0 = fcoc_pkg::ARG_ON;
          2: arg0 = fcoc_pkg::ARG_OFF;
          3: arg0 = BYTE_W'($urandom_range(3, 9));   // color range edges
          default: arg0 = BYTE_W'($urandom);
        endcase
        send_frame(cmd, len, arg0, $urandom_range(99) < 12);
      end
    end
    quiet <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst              = 1'b1;
    rx_ch.valid      = 1'b0;
    rx_ch.rx_byte    = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_idle_bytes();
    test_commands();
    test_bad_checksum();
    test_empty_frame();
    test_backpressure();
    test_long_frame();
    test_random_traffic();

    rx_ch.valid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
